// ----- sv/typed_slot_table_defines.svh -----
// Assertion macros used by the typed slot table datapath.
`ifndef TYPED_SLOT_TABLE_DEFINES_SVH
`define TYPED_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tst_pkg.sv -----
// Package with the shared types and constants of the typed slot table.
`timescale 1ns / 1ps

package tst_pkg;

  localparam int KEY_W   = 32;
  localparam int FIELD_W = 7;

  // Request codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_COUNT  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OOR  = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_busy;
    logic out_free;
    logic cfg_wr;
  } sts_t;

endpackage

// ----- sv/tst_if.sv -----
// Channel interfaces of the typed slot table: request, result and configuration.
`timescale 1ns / 1ps

interface tst_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [tst_pkg::KEY_W-1:0]        object_key;
  logic [tst_pkg::FIELD_W-1:0]      slot_index;
  logic [tst_pkg::FIELD_W-1:0]      remove_limit;

  modport source (output valid, req_type, object_key, slot_index, remove_limit,
                  input ready);
  modport sink   (input valid, req_type, object_key, slot_index, remove_limit,
                  output ready);
endinterface

interface tst_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [tst_pkg::FIELD_W-1:0]      match_count;
  logic                             slot_occupied;
  logic [tst_pkg::KEY_W-1:0]        slot_key;
  logic [tst_pkg::FIELD_W-1:0]      table_length;

  modport source (output valid, status, match_count, slot_occupied, slot_key,
                  table_length, input ready);
  modport sink   (input valid, status, match_count, slot_occupied, slot_key,
                  table_length, output ready);
endinterface

interface tst_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tst_pkg::FIELD_W-1:0]      data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/tst_ctrl.sv -----
// Controller state machine of the typed slot table.
`timescale 1ns / 1ps

module tst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tst_pkg::sts_t sts,
  output tst_pkg::cmd_t cmd
);

  tst_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tst_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      tst_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = tst_pkg::S_IDLE;
      end
      tst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tst_pkg::S_SCAN;
        end
      end
      tst_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (!sts.scan_busy) state_nxt = tst_pkg::S_FINISH;
      end
      tst_pkg::S_FINISH: begin
        // wait for the result register to free up
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = tst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tst_pkg::S_CLEAR;
      end
    endcase
    // a configuration write re-initializes the table
    if (sts.cfg_wr) state_nxt = tst_pkg::S_CLEAR;
  end

endmodule

// ----- sv/tst_datapath.sv -----
// Datapath of the typed slot table: slot memory, scan counters and result register.
`timescale 1ns / 1ps
`include "typed_slot_table_defines.svh"

module tst_datapath #(
  parameter int SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tst_pkg::cmd_t                cmd,
  output tst_pkg::sts_t                sts,
  // configuration
  input  logic                         cfg_fire,
  input  logic [tst_pkg::FIELD_W-1:0]  cfg_data,
  // request payload
  input  logic [1:0]                   in_req_type,
  input  logic [tst_pkg::KEY_W-1:0]    in_object_key,
  input  logic [tst_pkg::FIELD_W-1:0]  in_slot_index,
  input  logic [tst_pkg::FIELD_W-1:0]  in_remove_limit,
  // result channel
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [tst_pkg::FIELD_W-1:0]  out_match_count,
  output logic                         out_slot_occupied,
  output logic [tst_pkg::KEY_W-1:0]    out_slot_key,
  output logic [tst_pkg::FIELD_W-1:0]  out_table_length
);

  localparam int AW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int CW = (LW > tst_pkg::FIELD_W) ? LW : tst_pkg::FIELD_W;
  localparam int SW = CW + 1;
  localparam int MW = tst_pkg::KEY_W + 1;

  // slot memory: {valid, key}
  logic [MW-1:0] mem [SLOTS];
  logic [MW-1:0] rd_data_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;

  // table state
  logic [tst_pkg::FIELD_W-1:0] init_r;
  logic [LW-1:0]               app_r;
  logic [AW-1:0]               clr_cnt_r;

  // request context
  tst_pkg::op_t                op_r;
  logic [tst_pkg::KEY_W-1:0]   key_r;
  logic [tst_pkg::FIELD_W-1:0] limit_r;
  logic                        oor_r;
  logic [CW-1:0]               len_r;
  logic [CW-1:0]               addr_r;
  logic [CW-1:0]               end_r;
  logic [CW-1:0]               cnt_r;
  logic                        placed_r;
  logic                        occ_r;
  logic [tst_pkg::KEY_W-1:0]   rkey_r;

  // result register
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [tst_pkg::FIELD_W-1:0] out_match_r;
  logic                        out_occ_r;
  logic [tst_pkg::KEY_W-1:0]   out_key_r;
  logic [tst_pkg::FIELD_W-1:0] out_len_r;

  // current length at load time
  logic [SW-1:0] len_sum;
  logic [CW-1:0] len_now;
  logic [CW-1:0] idx_ext;
  logic          idx_in_rng;

  assign len_sum    = SW'(init_r) + SW'(app_r);
  assign len_now    = (len_sum > SW'(SLOTS)) ? CW'(SLOTS) : len_sum[CW-1:0];
  assign idx_ext    = CW'(in_slot_index);
  assign idx_in_rng = idx_ext < len_now;

  // scan issue and evaluation of the returned slot
  logic                      issue;
  logic                      e_valid;
  logic [tst_pkg::KEY_W-1:0] e_key;
  logic                      e_match;
  logic                      add_hit, rem_hit, cnt_hit, read_ev;

  assign issue   = cmd.scan && (addr_r < end_r);
  assign e_valid = rd_data_r[tst_pkg::KEY_W];
  assign e_key   = rd_data_r[tst_pkg::KEY_W-1:0];
  assign e_match = e_valid && (e_key == key_r);
  assign add_hit = rd_vld_r && (op_r == tst_pkg::OP_ADD) && !placed_r && !e_valid;
  assign rem_hit = rd_vld_r && (op_r == tst_pkg::OP_REMOVE) && e_match &&
                   (cnt_r < CW'(limit_r));
  assign cnt_hit = rd_vld_r && (op_r == tst_pkg::OP_COUNT) && e_match;
  assign read_ev = rd_vld_r && (op_r == tst_pkg::OP_READ);

  // end of operation decisions
  logic add_miss, append, full;

  assign add_miss = (op_r == tst_pkg::OP_ADD) && !placed_r;
  assign append   = add_miss && (len_r < CW'(SLOTS));
  assign full     = add_miss && !(len_r < CW'(SLOTS));

  // memory write port select
  logic          we;
  logic [AW-1:0] wa;
  logic [MW-1:0] wd;

  always_comb begin
    we = 1'b0;
    wa = rd_idx_r;
    wd = {1'b1, key_r};
    if (cmd.clr) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else if (cmd.finish && append) begin
      we = 1'b1;
      wa = len_r[AW-1:0];
    end else if (add_hit) begin
      we = 1'b1;
    end else if (rem_hit) begin
      we = 1'b1;
      wd = {1'b0, e_key};
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (issue) begin
      rd_data_r <= mem[addr_r[AW-1:0]];
      rd_idx_r  <= addr_r[AW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      init_r      <= '0;
      app_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cfg_fire) begin
        init_r <= cfg_data;
        app_r  <= '0;
      end else if (cmd.finish && append) begin
        app_r <= app_r + 1'b1;
      end
      if (cfg_fire) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request context and scan progress
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= tst_pkg::op_t'(in_req_type);
      key_r    <= in_object_key;
      limit_r  <= in_remove_limit;
      len_r    <= len_now;
      cnt_r    <= '0;
      placed_r <= 1'b0;
      occ_r    <= 1'b0;
      rkey_r   <= '0;
      if (tst_pkg::op_t'(in_req_type) == tst_pkg::OP_READ) begin
        addr_r <= idx_ext;
        end_r  <= idx_in_rng ? idx_ext + 1'b1 : idx_ext;
        oor_r  <= !idx_in_rng;
      end else begin
        addr_r <= '0;
        end_r  <= len_now;
        oor_r  <= 1'b0;
      end
    end else begin
      if (issue) addr_r <= addr_r + 1'b1;
      if (cnt_hit || rem_hit) cnt_r <= cnt_r + 1'b1;
      if (add_hit) placed_r <= 1'b1;
      if (read_ev) begin
        occ_r  <= e_valid;
        rkey_r <= e_valid ? e_key : '0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= full ? tst_pkg::ST_FULL : (oor_r ? tst_pkg::ST_OOR : tst_pkg::ST_OK);
      out_match_r  <= cnt_r[tst_pkg::FIELD_W-1:0];
      out_occ_r    <= occ_r;
      out_key_r    <= rkey_r;
      out_len_r    <= append ? len_r[tst_pkg::FIELD_W-1:0] + 1'b1
                             : len_r[tst_pkg::FIELD_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_match_count   = out_match_r;
  assign out_slot_occupied = out_occ_r;
  assign out_slot_key      = out_key_r;
  assign out_table_length  = out_len_r;

  // status toward the controller
  assign sts.clr_last  = (clr_cnt_r == AW'(SLOTS - 1));
  assign sts.scan_busy = (addr_r < end_r) || rd_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.cfg_wr    = cfg_fire;

  // checks
  `TST_ASSERT_IMP(a_finish_idle, clk, rst_n, cmd.finish, !sts.scan_busy, "finish during scan")
  `TST_ASSERT_IMP(a_issue_range, clk, rst_n, issue, addr_r < CW'(SLOTS), "scan past last slot")
  `TST_ASSERT_IMP(a_remove_limit, clk, rst_n, cmd.scan && (op_r == tst_pkg::OP_REMOVE), cnt_r <= CW'(limit_r), "remove over limit")
  `TST_ASSERT_NXT(a_append_grow, clk, rst_n, cmd.finish && append && !cfg_fire, app_r == LW'($past(app_r) + 1'b1), "append lost")

endmodule

// ----- sv/typed_slot_table.sv -----
// Top level of the typed slot table.
`timescale 1ns / 1ps

// Typed slot table: add, count, remove and read transactions on a table of up to
// SLOTS slots holding 32-bit keys. One request is processed at a time. Add, count
// and remove walk the slot memory one slot per cycle through its single read port;
// a read visits only the addressed slot, and an out-of-range read visits none. The
// result register lets a new request be accepted while the previous result waits.
// After reset and after every write of initial_slots, a clearing pass over all SLOTS
// slots empties the slot memory; no request is accepted during that pass.
// The configuration port is always ready; write it only while the block is idle.

module typed_slot_table #(
  parameter int SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  tst_req_if.sink   in_if,
  tst_rsp_if.source out_if,
  tst_cfg_if.sink   cfg_if
);

  tst_pkg::cmd_t cmd;
  tst_pkg::sts_t sts;
  logic          cfg_fire;

  // configuration transactions are taken at once
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;

  tst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tst_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_fire          (cfg_fire),
    .cfg_data          (cfg_if.data),
    .in_req_type       (in_if.req_type),
    .in_object_key     (in_if.object_key),
    .in_slot_index     (in_if.slot_index),
    .in_remove_limit   (in_if.remove_limit),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_status        (out_if.status),
    .out_match_count   (out_if.match_count),
    .out_slot_occupied (out_if.slot_occupied),
    .out_slot_key      (out_if.slot_key),
    .out_table_length  (out_if.table_length)
  );

endmodule

// ----- tb/typed_slot_table_test.sv -----
// Self-checking testbench of the typed slot table: directed table, then random phases.
`timescale 1ns / 1ps

module typed_slot_table_test;

  localparam int KEY_W          = tst_pkg::KEY_W;
  localparam int FIELD_W        = tst_pkg::FIELD_W;
  localparam int NSLOTS         = 64;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 140;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_CFG     = -1;

  // One result transaction as the block returns it
  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] match_count;
    logic               slot_occupied;
    logic [KEY_W-1:0]   slot_key;
    logic [FIELD_W-1:0] table_length;
  } slot_rsp_t;

  // Directed row: a register write or a request, optionally with a fixed answer
  typedef struct {
    bit                 is_cfg;
    bit                 typed;
    tst_pkg::op_t       op;
    logic [KEY_W-1:0]   key;
    logic [FIELD_W-1:0] idx;
    logic [FIELD_W-1:0] lim;
    slot_rsp_t          want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tst_req_if in_if ();
  tst_rsp_if out_if ();
  tst_cfg_if cfg_if ();

  typed_slot_table #(.SLOTS(NSLOTS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Shadow copy of the table
  logic [KEY_W-1:0] shadow_key [NSLOTS];
  bit               shadow_used [NSLOTS];
  int               grown_slots;
  int               start_slots;

  slot_rsp_t pending_rsp [$];
  dir_row_t  dir_rows [$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  bit        quiet;
  int        hold_seq;
  int        hold_ack    = 0;
  int        hold_left   = 0;
  int        stall_left  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int table_len();
    int sum;
    sum = start_slots + grown_slots;
    return (sum > NSLOTS) ? NSLOTS : sum;
  endfunction

  // Applies one request to the shadow table and returns the expected result
  function automatic slot_rsp_t apply_request(tst_pkg::op_t op, logic [KEY_W-1:0] key,
                                              logic [FIELD_W-1:0] idx,
                                              logic [FIELD_W-1:0] lim);
    slot_rsp_t r;
    int        len;
    int        cnt;
    bit        placed;
    r      = '0;
    len    = table_len();
    cnt    = 0;
    placed = 1'b0;
    case (op)
      tst_pkg::OP_ADD: begin
        for (int i = 0; i < len && !placed; i++) begin
          if (!shadow_used[i]) begin
            shadow_used[i] = 1'b1;
            shadow_key[i]  = key;
            placed         = 1'b1;
          end
        end
        if (!placed) begin
          if (len < NSLOTS) begin
            shadow_used[len] = 1'b1;
            shadow_key[len]  = key;
            grown_slots++;
          end else begin
            r.status = tst_pkg::ST_FULL;
          end
        end
      end
      tst_pkg::OP_COUNT: begin
        for (int i = 0; i < len; i++)
          if (shadow_used[i] && shadow_key[i] == key) cnt++;
      end
      tst_pkg::OP_REMOVE: begin
        for (int i = 0; i < len && cnt < lim; i++) begin
          if (shadow_used[i] && shadow_key[i] == key) begin
            shadow_used[i] = 1'b0;
            cnt++;
          end
        end
      end
      default: begin
        if (idx < len) begin
          r.slot_occupied = shadow_used[idx];
          r.slot_key      = shadow_used[idx] ? shadow_key[idx] : '0;
        end else begin
          r.status = tst_pkg::ST_OOR;
        end
      end
    endcase
    r.match_count  = cnt[FIELD_W-1:0];
    r.table_length = FIELD_W'(table_len());
    return r;
  endfunction

  function automatic void dir_cfg(logic [FIELD_W-1:0] value);
    dir_row_t row;
    row        = '{op: tst_pkg::OP_ADD, default: '0};
    row.is_cfg = 1'b1;
    row.idx    = value;
    dir_rows   = {dir_rows, row};
  endfunction

  function automatic void dir_req(tst_pkg::op_t op, logic [KEY_W-1:0] key,
                                  logic [FIELD_W-1:0] idx, logic [FIELD_W-1:0] lim);
    dir_row_t row;
    row      = '{op: tst_pkg::OP_ADD, default: '0};
    row.op   = op;
    row.key  = key;
    row.idx  = idx;
    row.lim  = lim;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void dir_chk(tst_pkg::op_t op, logic [KEY_W-1:0] key,
                                  logic [FIELD_W-1:0] idx, logic [FIELD_W-1:0] lim,
                                  logic [1:0] st, logic [FIELD_W-1:0] cnt, logic occ,
                                  logic [KEY_W-1:0] skey, logic [FIELD_W-1:0] len);
    dir_row_t row;
    row       = '{op: tst_pkg::OP_ADD, default: '0};
    row.typed = 1'b1;
    row.op    = op;
    row.key   = key;
    row.idx   = idx;
    row.lim   = lim;
    row.want  = '{st, cnt, occ, skey, len};
    dir_rows  = {dir_rows, row};
  endfunction

  // Offers one request, waits for its transaction and books the expected result
  task automatic send_req(tst_pkg::op_t op, logic [KEY_W-1:0] key,
                          logic [FIELD_W-1:0] idx, logic [FIELD_W-1:0] lim,
                          bit typed, slot_rsp_t want);
    slot_rsp_t model;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.req_type     <= op;
    in_if.object_key   <= key;
    in_if.slot_index   <= idx;
    in_if.remove_limit <= lim;
    do @(posedge clk); while (!in_if.ready);
    model       = apply_request(op, key, idx, lim);
    pending_rsp = {pending_rsp, typed ? want : model};
  endtask

  // Writes initial_slots once every result is back; the table restarts empty
  task automatic write_cfg(logic [FIELD_W-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    start_slots = int'(value);
    grown_slots = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_seq != hold_ack) begin
      hold_ack  = hold_seq;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    slot_rsp_t got;
    slot_rsp_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.status, out_if.match_count, out_if.slot_occupied, out_if.slot_key,
              out_if.table_length};
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d count %0d occ %0d key %h len %0d",
                   got.status, got.match_count, got.slot_occupied, got.slot_key,
                   got.table_length);
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.match_count !== want.match_count ||
            got.slot_occupied !== want.slot_occupied || got.slot_key !== want.slot_key ||
            got.table_length !== want.table_length) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp st %0d cnt %0d occ %0d key %h len %0d, got st %0d cnt %0d occ %0d key %h len %0d",
                     want.status, want.match_count, want.slot_occupied, want.slot_key,
                     want.table_length, got.status, got.match_count, got.slot_occupied,
                     got.slot_key, got.table_length);
        end
      end
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("typed_slot_table_test failed");
        $finish;
      end
    end
  end

  initial begin
    int                 cfg_plan [PHASES];
    int                 add_plan [PHASES];
    logic [KEY_W-1:0]   pool [4];
    logic [KEY_W-1:0]   key;
    logic [FIELD_W-1:0] idx;
    logic [FIELD_W-1:0] lim;
    tst_pkg::op_t       op;
    int                 pick;
    int                 cfg_value;

    cfg_plan    = '{64, 1, 0, 127, 2, RANDOM_CFG, 64, 63, 65, RANDOM_CFG, 10, 64};
    add_plan    = '{90, 50, 60, 90, 40, 50, 85, 45, 60, 50, 70, 55};
    quiet       = 1'b0;
    hold_seq    = 0;
    start_slots = 0;
    grown_slots = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end
    in_if.valid        <= 1'b0;
    in_if.req_type     <= tst_pkg::OP_ADD;
    in_if.object_key   <= '0;
    in_if.slot_index   <= '0;
    in_if.remove_limit <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= '0;

    // Directed table: empty table after reset, limits, oversized register, re-init
    dir_chk(tst_pkg::OP_READ, 32'h0, 7'd0, 7'd0, tst_pkg::ST_OOR, 7'd0, 1'b0, 32'h0, 7'd0);
    dir_chk(tst_pkg::OP_COUNT, 32'h0, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0, 7'd0);
    dir_chk(tst_pkg::OP_REMOVE, 32'h0, 7'd0, 7'd64, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0, 7'd0);
    dir_chk(tst_pkg::OP_ADD, 32'hFFFFFFFF, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0,
            7'd1);
    dir_chk(tst_pkg::OP_ADD, 32'h0, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0, 7'd2);
    dir_chk(tst_pkg::OP_ADD, 32'hFFFFFFFF, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0,
            7'd3);
    dir_chk(tst_pkg::OP_READ, 32'h0, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b1, 32'hFFFFFFFF,
            7'd3);
    dir_chk(tst_pkg::OP_READ, 32'h0, 7'd127, 7'd0, tst_pkg::ST_OOR, 7'd0, 1'b0, 32'h0, 7'd3);
    dir_chk(tst_pkg::OP_COUNT, 32'hFFFFFFFF, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd2, 1'b0, 32'h0,
            7'd3);
    dir_chk(tst_pkg::OP_REMOVE, 32'hFFFFFFFF, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0,
            7'd3);
    dir_chk(tst_pkg::OP_REMOVE, 32'hFFFFFFFF, 7'd0, 7'd1, tst_pkg::ST_OK, 7'd1, 1'b0, 32'h0,
            7'd3);
    dir_chk(tst_pkg::OP_READ, 32'h0, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0, 7'd3);
    dir_req(tst_pkg::OP_ADD,    32'hA5A5A5A5, 7'd127, 7'd127);
    dir_req(tst_pkg::OP_READ,   32'hFFFFFFFF, 7'd2,   7'd127);
    dir_req(tst_pkg::OP_REMOVE, 32'h0,        7'd127, 7'd127);
    dir_req(tst_pkg::OP_COUNT,  32'h0,        7'd0,   7'd0);
    dir_chk(tst_pkg::OP_READ, 32'h0, 7'd3, 7'd0, tst_pkg::ST_OOR, 7'd0, 1'b0, 32'h0, 7'd3);
    dir_cfg(7'd127);
    dir_chk(tst_pkg::OP_READ, 32'h0, 7'd63, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0, 7'd64);
    dir_chk(tst_pkg::OP_READ, 32'h0, 7'd64, 7'd0, tst_pkg::ST_OOR, 7'd0, 1'b0, 32'h0, 7'd64);
    dir_chk(tst_pkg::OP_ADD, 32'h12345678, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0,
            7'd64);
    dir_req(tst_pkg::OP_READ,   32'h0,        7'd0,   7'd0);
    dir_cfg(7'd0);
    dir_chk(tst_pkg::OP_ADD, 32'h5A5A5A5A, 7'd0, 7'd0, tst_pkg::ST_OK, 7'd0, 1'b0, 32'h0,
            7'd1);
    dir_req(tst_pkg::OP_COUNT,  32'h5A5A5A5A, 7'd0,   7'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg)
        write_cfg(dir_rows[r].idx);
      else
        send_req(dir_rows[r].op, dir_rows[r].key, dir_rows[r].idx, dir_rows[r].lim,
                 dir_rows[r].typed, dir_rows[r].want);
    end

    // Random phases, each with its own table size and key pool
    for (int p = 0; p < PHASES; p++) begin
      cfg_value = (cfg_plan[p] == RANDOM_CFG) ? $urandom_range(0, NSLOTS) : cfg_plan[p];
      write_cfg(cfg_value[FIELD_W-1:0]);
      quiet   = (p == PHASES - 1);
      pool[0] = $urandom;
      pool[1] = $urandom;
      pool[2] = ~pool[0];
      pool[3] = pool[0] ^ 32'h1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == 20) hold_seq++;
        pick = $urandom_range(0, 99);
        if (pick < add_plan[p])
          op = tst_pkg::OP_ADD;
        else
          case ($urandom_range(0, 2))
            0:       op = tst_pkg::OP_COUNT;
            1:       op = tst_pkg::OP_REMOVE;
            default: op = tst_pkg::OP_READ;
          endcase
        key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 3)];
        idx = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom_range(0, 127))
                                          : FIELD_W'($urandom_range(0, table_len()));
        lim = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom_range(0, 127))
                                          : FIELD_W'($urandom_range(0, 3));
        send_req(op, key, idx, lim, 1'b0, '0);
      end
    end

    // Drain, then let the block settle
    in_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("typed_slot_table_test passed");
    end else begin
      $display("typed_slot_table_test failed");
    end
    $finish;
  end

endmodule
